// ===== rtl/core/lwfm_pkg.sv =====
// Shared types and constants for the longest-window-few-marks block.
package lwfm_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SYM_W      = 8;
  localparam int MARKS_W    = 6;
  localparam int LEN_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MARKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_SYMBOL = 1'b1;

  localparam logic [MARKS_W-1:0] MAX_MARKS_RST   = 6'd0;
  localparam logic [SYM_W-1:0]   MARK_SYMBOL_RST = 8'd46;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] best_length;
    logic             overflow;
  } lwfm_result_t;

endpackage

// ===== rtl/core/lwfm_mark_ram.sv =====
// Mark position memory: one write port, one registered read port with write-through.
module lwfm_mark_ram
  import lwfm_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a same-cycle write so the head entry is never stale
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/lwfm_scan.sv =====
// Window scan: mark FIFO pointers, window start, position and best length.
module lwfm_scan
  import lwfm_pkg::*;
#(
  parameter int MARK_FIFO_DEPTH = 64,
  parameter int POS_BITS        = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_fire,
  input  logic [SYM_W-1:0]   symbol,
  input  logic               last,
  input  logic [MARKS_W-1:0] max_marks,
  input  logic [SYM_W-1:0]   mark_symbol,
  output lwfm_result_t       result
);

  localparam int IW = $clog2(MARK_FIFO_DEPTH);
  localparam int CW = $clog2(MARK_FIFO_DEPTH + 1);
  localparam int LW = (CW > MARKS_W) ? CW : MARKS_W;
  localparam int OW = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam int P  = POS_BITS;

  logic [CW-1:0] count_r, count_nxt, count_pop;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [P-1:0]  ws_r, ws_nxt, pos_r, pos_nxt, best_r, best_nxt;
  logic          ovf_r, ovf_nxt;

  logic [P-1:0]  head_pos, pos_inc, len, best_fin;
  logic [LW-1:0] limit, cnt_ext, cnt_pop_ext;
  logic          ovf_hit, active, is_mark, full, pop, skip, push, clear, ovf_fin, sat;
  logic [OW-1:0] best_ext;

  lwfm_mark_ram #(
    .DEPTH  (MARK_FIFO_DEPTH),
    .DATA_W (P)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail_r),
    .wr_data (pos_r),
    .rd_addr (head_nxt),
    .rd_data (head_pos)
  );

  always_comb begin
    ovf_hit = (pos_r == {P{1'b1}});
    active  = item_fire && !ovf_hit && !ovf_r;
    is_mark = (symbol == mark_symbol);
    limit   = (LW'(max_marks) > LW'(MARK_FIFO_DEPTH)) ? LW'(MARK_FIFO_DEPTH)
                                                       : LW'(max_marks);
    cnt_ext = LW'(count_r);
    full    = (cnt_ext >= limit);
    pop     = active && is_mark && full && (count_r != '0);
    skip    = active && is_mark && full && (count_r == '0);
    count_pop   = pop ? (count_r - CW'(1)) : count_r;
    cnt_pop_ext = LW'(count_pop);
    push    = active && is_mark && (cnt_pop_ext < limit);
    pos_inc = pos_r + P'(1);

    // window length ending at the current symbol
    if (pop) begin
      ws_nxt = head_pos + P'(1);
      len    = pos_r - head_pos;
    end else if (skip) begin
      ws_nxt = pos_inc;
      len    = '0;
    end else begin
      ws_nxt = ws_r;
      len    = pos_inc - ws_r;
    end

    best_fin = (active && (len > best_r)) ? len : best_r;
    ovf_fin  = ovf_r || (item_fire && ovf_hit);
    clear    = item_fire && last;

    head_nxt = head_r;
    if (pop) begin
      head_nxt = (head_r == IW'(MARK_FIFO_DEPTH - 1)) ? '0 : head_r + IW'(1);
    end
    tail_nxt  = tail_r;
    count_nxt = count_pop;
    if (push) begin
      tail_nxt  = (tail_r == IW'(MARK_FIFO_DEPTH - 1)) ? '0 : tail_r + IW'(1);
      count_nxt = count_pop + CW'(1);
    end
    pos_nxt  = active ? pos_inc : pos_r;
    best_nxt = best_fin;
    ovf_nxt  = ovf_fin;
    if (!active) begin
      ws_nxt = ws_r;
    end

    // drop all stream state after the last beat
    if (clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      pos_nxt   = '0;
      ws_nxt    = '0;
      best_nxt  = '0;
      ovf_nxt   = 1'b0;
    end

    best_ext           = OW'(best_fin);
    sat                = ovf_fin || (best_ext > OW'(32'h0000_FFFF));
    result.valid       = clear;
    result.best_length = sat ? {LEN_W{1'b1}} : best_ext[LEN_W-1:0];
    result.overflow    = ovf_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      ws_r    <= '0;
      pos_r   <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      ws_r    <= ws_nxt;
      pos_r   <= pos_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/core/longest_window_few_marks.sv =====
// Top level: configuration registers, input handshake and result register.
//
// Usage:
//   Input beats (in_symbol, in_last) are taken when in_valid is high and
//   in_stall is low. Each beat is one symbol of a stream; in_last closes it.
//   A symbol equal to mark_symbol counts as a mark. For each stream one
//   result beat (out_best_length, out_overflow) is produced: the longest
//   window holding at most max_marks marks, saturated at 65535; out_overflow
//   is set when the stream ran past 2^POS_BITS - 1 symbols.
//   Throughput: one beat per cycle while in_stall is low; each beat updates the mark FIFO memory
//   and the window registers in the cycle it is accepted, with the FIFO head
//   prefetched through the memory's registered read port.
//   Latency: the result is valid in the cycle after the last beat is taken.
//   Stall: while a result waits with out_stall high, in_stall is raised;
//   otherwise input is taken every cycle.
//   Configuration: cfg_ready is always high; index 0 is max_marks, index 1
//   is mark_symbol. Write only while the block is idle.
//   Reset: clears all stream state, max_marks to 0 and mark_symbol to '.'.
//   No memory clearing pass is needed; the block is ready right after reset.
module longest_window_few_marks
  import lwfm_pkg::*;
#(
  parameter int MARK_FIFO_DEPTH = 64,
  parameter int POS_BITS        = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEN_W-1:0]      out_best_length,
  output logic                  out_overflow,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MARKS_W-1:0] max_marks_r;
  logic [SYM_W-1:0]   mark_symbol_r;
  logic               item_fire;
  lwfm_result_t       result;
  logic               out_valid_r;
  logic [LEN_W-1:0]   best_length_r;
  logic               overflow_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign item_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_marks_r   <= MAX_MARKS_RST;
      mark_symbol_r <= MARK_SYMBOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_MARKS:   max_marks_r   <= cfg_data[MARKS_W-1:0];
        CFG_MARK_SYMBOL: mark_symbol_r <= cfg_data[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  lwfm_scan #(
    .MARK_FIFO_DEPTH (MARK_FIFO_DEPTH),
    .POS_BITS        (POS_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (item_fire),
    .symbol      (in_symbol),
    .last        (in_last),
    .max_marks   (max_marks_r),
    .mark_symbol (mark_symbol_r),
    .result      (result)
  );

  // hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      best_length_r <= result.best_length;
      overflow_r    <= result.overflow;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_length = best_length_r;
  assign out_overflow    = overflow_r;

endmodule

// ===== verif/lwfm_window_checker.sv =====
// Window predictor and result scoreboard for longest_window_few_marks.
module lwfm_window_checker
  import lwfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [LEN_W-1:0]      out_best_length,
  input  logic                  out_overflow,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIFO_DEPTH = 64;
  localparam int          IDX_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned POS_LIMIT  = (1 << 16) - 1;
  localparam int unsigned REPORT_MAX = 10;

  logic [MARKS_W-1:0] max_marks_q;
  logic [SYM_W-1:0]   mark_sym_q;

  int unsigned      mark_pos [FIFO_DEPTH];
  int unsigned      marks_held;
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] tail_idx;
  int unsigned      win_start;
  int unsigned      sym_pos;
  int unsigned      best_len;
  bit               ovf;

  lwfm_result_t expected_best [$];

  function automatic void clear_stream();
    marks_held = 0;
    head_idx   = '0;
    tail_idx   = '0;
    win_start  = 0;
    sym_pos    = 0;
    best_len   = 0;
    ovf        = 1'b0;
  endfunction

  // Advance the window by one symbol; queue the stream's answer on the last one.
  task automatic advance_window(input logic [SYM_W-1:0] sym, input logic last);
    int unsigned  limit;
    int unsigned  run_len;
    lwfm_result_t res;
    limit = (max_marks_q > FIFO_DEPTH) ? FIFO_DEPTH : max_marks_q;
    if (sym_pos >= POS_LIMIT) begin
      ovf = 1'b1;
    end else if (!ovf) begin
      if (sym == mark_sym_q) begin
        if (marks_held >= limit) begin
          // drop the oldest mark and move the window start past it
          if (marks_held > 0) begin
            win_start  = mark_pos[head_idx] + 1;
            head_idx   = (head_idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_idx + IDX_W'(1);
            marks_held = marks_held - 1;
          end else begin
            win_start = sym_pos + 1;
          end
        end
        if (marks_held < limit) begin
          mark_pos[tail_idx] = sym_pos;
          tail_idx   = (tail_idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : tail_idx + IDX_W'(1);
          marks_held = marks_held + 1;
        end
      end
      run_len = sym_pos + 1 - win_start;
      if (run_len > best_len) best_len = run_len;
      sym_pos = sym_pos + 1;
    end
    if (last) begin
      res.valid       = 1'b1;
      res.best_length = (ovf || best_len > 32'hFFFF) ? 16'hFFFF : best_len[LEN_W-1:0];
      res.overflow    = ovf;
      expected_best   = {expected_best, res};
      clear_stream();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_marks_q = MAX_MARKS_RST;
      mark_sym_q  = MARK_SYMBOL_RST;
      clear_stream();
      expected_best.delete();
      mismatches  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_MARKS) max_marks_q = cfg_data[MARKS_W-1:0];
        else                            mark_sym_q  = cfg_data;
      end
      // check the result beat before adding this edge's prediction
      if (out_valid && !out_stall) begin
        if (expected_best.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result beat: best_length %0d overflow %0d",
                     $realtime, out_best_length, out_overflow);
        end else begin
          lwfm_result_t exp_res;
          exp_res = expected_best.pop_front();
          if (out_best_length !== exp_res.best_length ||
              out_overflow !== exp_res.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch: best_length exp %0d got %0d, overflow exp %0d got %0d",
                       $realtime, exp_res.best_length, out_best_length,
                       exp_res.overflow, out_overflow);
          end
        end
      end
      if (in_valid && !in_stall) advance_window(in_symbol, in_last);
    end
    pending_results = expected_best.size();
  end

endmodule

// ===== verif/longest_window_few_marks_tb.sv =====
// Stimulus and verdict for the longest_window_few_marks testbench.
module longest_window_few_marks_tb
  import lwfm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_LEN    = 150;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 370;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SYM_W-1:0]      in_symbol;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEN_W-1:0]      out_best_length;
  logic                  out_overflow;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int pending_results;
  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_requests;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int idle_run = 0;
  int items_sent;
  logic [SYM_W-1:0] cur_mark;

  longest_window_few_marks i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_length (out_best_length),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  lwfm_window_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_length (out_best_length),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (holdoff_seen != holdoff_requests) begin
      holdoff_seen = holdoff_requests;
      holdoff_left = HOLDOFF_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("FAIL longest_window_few_marks");
        $finish;
      end
    end
  end

  // Offer one symbol beat, idling first at random; returns at the falling edge after the beat is taken.
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_symbol(s[i], close && (i == s.len() - 1));
  endtask

  // Hold input and wait until every result is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [MARKS_W-1:0] marks, input logic [SYM_W-1:0] mark);
    write_reg(CFG_MAX_MARKS, {{(CFG_DATA_W - MARKS_W){1'b0}}, marks});
    write_reg(CFG_MARK_SYMBOL, mark);
    cfg_valid <= 1'b0;
    cur_mark = mark;
  endtask

  task automatic reconfigure();
    logic [MARKS_W-1:0] marks;
    logic [SYM_W-1:0]   mark;
    case ($urandom_range(5))
      0:       marks = '0;
      1:       marks = '1;
      2:       marks = MARKS_W'(1);
      default: marks = MARKS_W'($urandom_range(63));
    endcase
    if ($urandom_range(9) < 7) mark = MARK_SYMBOL_RST;
    else                       mark = SYM_W'($urandom_range(255));
    settle();
    set_config(marks, mark);
  endtask

  // Mostly short streams; a few long ones, with a random mark density, that can fill the FIFO.
  task automatic send_random_stream();
    int               len;
    int               density;
    int               pick;
    logic [SYM_W-1:0] sym;
    pick = $urandom_range(99);
    if (pick < 85)      len = $urandom_range(24, 1);
    else if (pick < 95) len = $urandom_range(120, 25);
    else                len = $urandom_range(300, 121);
    density = $urandom_range(100);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < density) sym = cur_mark;
      else                              sym = SYM_W'($urandom_range(255));
      send_symbol(sym, i == len - 1);
    end
  endtask

  task automatic run_random_phase(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(3) == 0) reconfigure();
      send_random_stream();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_symbol        = '0;
    in_last          = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    holdoff_requests = 0;
    items_sent       = 0;
    cur_mark         = MARK_SYMBOL_RST;
    send_idle_pct    = 21;
    recv_idle_pct    = 79;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: limit zero, period is the mark
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b0);
    send_text(".AB", 1'b1);
    send_text(".", 1'b1);
    settle();
    set_config('1, 8'hFF);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(MARK_SYMBOL_RST, 1'b1);
    settle();
    set_config(MARKS_W'(1), MARK_SYMBOL_RST);
    send_text(".a.bc.d", 1'b1);
    settle();
    // lower the limit in the middle of a stream full of marks
    set_config(MARKS_W'(3), MARK_SYMBOL_RST);
    send_text("...x", 1'b0);
    settle();
    set_config(MARKS_W'(1), MARK_SYMBOL_RST);
    send_text(".y", 1'b1);

    holdoff_requests++;
    run_random_phase(PHASE_ITEMS);
    settle();

    send_idle_pct = 79;
    recv_idle_pct = 21;
    run_random_phase(PHASE_ITEMS);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PHASE_ITEMS);
    settle();
    repeat (20) @(negedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASS longest_window_few_marks");
    end else begin
      $display("FAIL longest_window_few_marks");
    end
    $finish;
  end

endmodule
